// ===== rtl/core/utf8_stream_decoder_defines.svh =====
// Assertion macros shared by the decoder RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define U8SD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define U8SD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define U8SD_ASSERT(lbl, clk, rst_n, prop, msg)
`define U8SD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/core/u8sd_pkg.sv =====
package u8sd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CP_W      = 26;
	localparam int unsigned PEND_W    = 3;
	localparam int unsigned CONT_BITS = 6;

	// Continuation bytes still expected after each kind of lead
	localparam logic [PEND_W-1:0] PEND_NONE  = 3'd0;
	localparam logic [PEND_W-1:0] PEND_TWO   = 3'd1;
	localparam logic [PEND_W-1:0] PEND_THREE = 3'd2;
	localparam logic [PEND_W-1:0] PEND_FOUR  = 3'd3;
	localparam logic [PEND_W-1:0] PEND_FIVE  = 3'd4;

	// Lead byte ranges
	localparam logic [BYTE_W-1:0] ASCII_LAST = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hF7;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              end_of_text;
	} u8sd_item_t;

	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] code_point;
		logic            final_char;
		logic            truncated;
	} u8sd_result_t;

	typedef struct packed {
		logic [PEND_W-1:0] pending;
		logic              open_seq;
	} u8sd_status_t;

endpackage

// ===== rtl/core/u8sd_if.sv =====
interface u8sd_byte_if
	import u8sd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_in;
	logic              end_of_text;

	modport source (output valid, byte_in, end_of_text, input ready);
	modport sink   (input valid, byte_in, end_of_text, output ready);
endinterface

interface u8sd_char_if
	import u8sd_pkg::*;
;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            final_char;
	logic            truncated;

	modport source (output valid, code_point, final_char, truncated, input ready);
	modport sink   (input valid, code_point, final_char, truncated, output ready);
endinterface

// ===== rtl/core/u8sd_in_reg.sv =====
module u8sd_in_reg
	import u8sd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	u8sd_byte_if.sink   byte_ch,
	input  logic        fire,
	output logic        valid_s1,
	output u8sd_item_t  item_s1
);

	logic take;

	// Take a new transaction when the stage is empty or drains this cycle
	assign byte_ch.ready = !valid_s1 || fire;
	assign take          = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	// Capture payload on acceptance only
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.byte_in     <= byte_ch.byte_in;
			item_s1.end_of_text <= byte_ch.end_of_text;
		end
	end

endmodule

// ===== rtl/core/u8sd_decode.sv =====
module u8sd_decode
	import u8sd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  u8sd_item_t    item_s1,
	input  logic          valid_s1,
	input  logic          fire,
	output u8sd_result_t  res,
	output u8sd_status_t  status
);

	logic [CP_W-1:0]   acc_q;
	logic [PEND_W-1:0] pend_q;
	logic [CP_W-1:0]   acc_d;
	logic [PEND_W-1:0] pend_d;
	logic              done;

	// Fold one byte into the open sequence or start a new one
	always_comb begin
		logic [BYTE_W-1:0] b;
		b      = item_s1.byte_in;
		acc_d  = acc_q;
		pend_d = pend_q;
		done   = 1'b0;
		if (pend_q != PEND_NONE) begin
			acc_d  = {acc_q[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
			pend_d = pend_q - PEND_TWO;
			done   = (pend_d == PEND_NONE);
		end else if (b inside {[8'h00:ASCII_LAST]}) begin
			acc_d = {{(CP_W-BYTE_W){1'b0}}, b};
			done  = 1'b1;
		end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
			acc_d  = {{(CP_W-5){1'b0}}, b[4:0]};
			pend_d = PEND_TWO;
		end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
			acc_d  = {{(CP_W-4){1'b0}}, b[3:0]};
			pend_d = PEND_THREE;
		end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
			acc_d  = {{(CP_W-3){1'b0}}, b[2:0]};
			pend_d = PEND_FOUR;
		end else begin
			// Stray continuation or 0xF8..0xFF: five-byte lead
			acc_d  = {{(CP_W-2){1'b0}}, b[1:0]};
			pend_d = PEND_FIVE;
		end
	end

	assign res.valid      = valid_s1 && (done || item_s1.end_of_text);
	assign res.code_point = acc_d;
	assign res.final_char = item_s1.end_of_text;
	assign res.truncated  = item_s1.end_of_text && !done;

	assign status.pending  = pend_q;
	assign status.open_seq = (pend_q != PEND_NONE);

	// Advance state; drop it back to empty whenever a result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= PEND_NONE;
		end else if (fire) begin
			if (done || item_s1.end_of_text) begin
				acc_q  <= '0;
				pend_q <= PEND_NONE;
			end else begin
				acc_q  <= acc_d;
				pend_q <= pend_d;
			end
		end
	end

endmodule

// ===== rtl/core/u8sd_out_reg.sv =====
module u8sd_out_reg
	import u8sd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  u8sd_result_t  res,
	input  logic          load,
	output logic          out_free,
	u8sd_char_if.source   char_ch
);

	logic            out_valid_q;
	logic [CP_W-1:0] cp_q;
	logic            final_q;
	logic            trunc_q;

	assign out_free = !out_valid_q || char_ch.ready;

	// Hold the result until the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (char_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q    <= res.code_point;
			final_q <= res.final_char;
			trunc_q <= res.truncated;
		end
	end

	assign char_ch.valid      = out_valid_q;
	assign char_ch.code_point = cp_q;
	assign char_ch.final_char = final_q;
	assign char_ch.truncated  = trunc_q;

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// Channel   Dir  Payload                                  Handshake
// byte_ch   in   byte_in[7:0], end_of_text                valid/ready
// char_ch   out  code_point[25:0], final_char, truncated  valid/ready
//
// One byte per cycle sustained, unless a result meets a stalled output register.
// A result passes from the input register through the decode step into the result register.
// arst_n clears both stage valids, the accumulator and the pending count.
// A stalled output holds its result; the input stage keeps taking bytes that
// produce no result and stops only when a result cannot be loaded.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder
	import u8sd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	u8sd_byte_if.sink   byte_ch,
	u8sd_char_if.source char_ch
);

	logic         valid_s1;
	u8sd_item_t   item_s1;
	u8sd_result_t res;
	u8sd_status_t status;
	logic         out_free;
	logic         fire;

	// Retire the staged byte when its result has room, or when it has none
	assign fire = valid_s1 && (out_free || !res.valid);

	u8sd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	u8sd_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1),
		.fire     (fire),
		.res      (res),
		.status   (status)
	);

	u8sd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.load     (fire && res.valid),
		.out_free (out_free),
		.char_ch  (char_ch)
	);

	`U8SD_ASSERT(a_trunc_is_final, clk, arst_n, (char_ch.valid && char_ch.truncated) |-> char_ch.final_char, "truncated result without final_char")
	`U8SD_ASSERT(a_eot_clears, clk, arst_n, (fire && item_s1.end_of_text) |=> !status.open_seq, "sequence still open after end of text")
	`U8SD_ASSERT_NEVER(a_pend_range, clk, arst_n, status.pending > PEND_FIVE, "pending count out of range")
	`U8SD_ASSERT_NEVER(a_no_overwrite, clk, arst_n, fire && res.valid && !out_free, "result register overwritten")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import u8sd_pkg::*;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            final_char;
		logic            truncated;
	} decoded_char_t;

	// One byte of text; a literal row carries its expected character inline
	typedef struct packed {
		logic [BYTE_W-1:0] byte_val;
		logic              eot;
		logic              literal;
		logic [CP_W-1:0]   cp;
		logic              fin;
		logic              trunc;
	} text_row_t;

	localparam logic LIT  = 1'b1;
	localparam logic PRED = 1'b0;
	localparam int   N_DIRECTED    = 25;
	localparam int   TEXT_BYTES    = 1875;
	localparam int   SETTLE_BYTES  = 150;
	localparam int   DRAIN_CYCLES  = 20;

	// Hand-written text: extremes, each lead class, stray and ASCII continuations,
	// end of string inside and after a character
	text_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00, 1'b0, LIT,  26'h0000000, 1'b0, 1'b0},
		'{8'h7F, 1'b0, LIT,  26'h000007F, 1'b0, 1'b0},
		'{8'hC3, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hA9, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hE2, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h82, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hAC, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hF0, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h9F, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h98, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h80, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hFF, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hBF, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hBF, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hBF, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hBF, 1'b0, LIT,  26'h3FFFFFF, 1'b0, 1'b0},
		'{8'h80, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h41, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h42, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h43, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h44, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'hE2, 1'b0, PRED, 26'h0,       1'b0, 1'b0},
		'{8'h82, 1'b1, LIT,  26'h0000082, 1'b1, 1'b1},
		'{8'h41, 1'b1, LIT,  26'h0000041, 1'b1, 1'b0},
		'{8'hC0, 1'b1, LIT,  26'h0000000, 1'b1, 1'b1}
	};

	logic clk;
	logic arst_n;

	u8sd_byte_if byte_ch ();
	u8sd_char_if char_ch ();

	utf8_stream_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.char_ch (char_ch)
	);

	text_row_t         byte_plan [$];
	decoded_char_t     pending_chars [$];
	logic [CP_W-1:0]   acc_bits;
	logic [PEND_W-1:0] conts_left;
	int                bytes_sent;
	int                errors;
	bit                settle_phase;

	// Rebuild one code point step; returns 1 when the byte completes a character
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eot,
		output decoded_char_t ch);
		bit done;
		done = 1'b0;
		ch = '0;
		if (conts_left != PEND_NONE) begin
			acc_bits = {acc_bits[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
			conts_left = conts_left - 1'b1;
			done = (conts_left == PEND_NONE);
		end else if (b <= ASCII_LAST) begin
			acc_bits = CP_W'(b);
			done = 1'b1;
		end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			acc_bits = CP_W'(b[4:0]);
			conts_left = PEND_TWO;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			acc_bits = CP_W'(b[3:0]);
			conts_left = PEND_THREE;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			acc_bits = CP_W'(b[2:0]);
			conts_left = PEND_FOUR;
		end else begin
			// stray continuation or 0xF8..0xFF: five-byte lead
			acc_bits = CP_W'(b[1:0]);
			conts_left = PEND_FIVE;
		end
		if (!done && !eot)
			return 1'b0;
		ch.code_point = acc_bits;
		ch.final_char = eot;
		ch.truncated  = eot && !done;
		acc_bits = '0;
		conts_left = PEND_NONE;
		return 1'b1;
	endfunction

	// Append random text: mostly well-formed characters, some noise and early ends
	task automatic add_random_text(input int target);
		logic [BYTE_W-1:0] seq [5];
		text_row_t row;
		int len;
		int kind;
		int cut;
		while (byte_plan.size() < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				len = 1;
				seq[0] = 8'($urandom_range(0, 127));
			end else if (kind < 45) begin
				len = 2;
				seq[0] = {3'b110, 5'($urandom)};
			end else if (kind < 60) begin
				len = 3;
				seq[0] = {4'b1110, 4'($urandom)};
			end else if (kind < 75) begin
				len = 4;
				seq[0] = {5'b11110, 3'($urandom)};
			end else if (kind < 88) begin
				len = 5;
				seq[0] = $urandom_range(0, 1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
			end else begin
				len = $urandom_range(1, 5);
				for (int k = 0; k < len; k++)
					seq[k] = 8'($urandom);
			end
			if (kind < 88) begin
				for (int k = 1; k < len; k++)
					seq[k] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
			end
			// pick where the string ends, if it ends here at all
			cut = len - 1;
			if ($urandom_range(0, 15) != 0)
				cut = -1;
			else if ($urandom_range(0, 1) == 0)
				cut = $urandom_range(0, len - 1);
			for (int k = 0; k < len; k++) begin
				row = '0;
				row.byte_val = seq[k];
				row.eot = (k == cut);
				byte_plan.push_back(row);
				if (k == cut)
					break;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive byte transactions; predict each one as it is accepted
	initial begin : drive_bytes
		decoded_char_t ch;
		text_row_t cur;
		int gap;
		byte_ch.valid <= 1'b0;
		byte_ch.byte_in <= '0;
		byte_ch.end_of_text <= 1'b0;
		gap = 0;
		wait (arst_n === 1'b1);
		while (bytes_sent < byte_plan.size()) begin
			@(posedge clk);
			if (byte_ch.valid && byte_ch.ready) begin
				cur = byte_plan[bytes_sent];
				if (decode_byte(cur.byte_val, cur.eot, ch)) begin
					if (cur.literal)
						ch = '{cur.cp, cur.fin, cur.trunc};
					pending_chars.push_back(ch);
				end
				bytes_sent++;
				if (bytes_sent >= byte_plan.size() - SETTLE_BYTES)
					settle_phase = 1'b1;
				if (!settle_phase && $urandom_range(0, 7) == 0)
					gap = $urandom_range(1, 11);
			end
			if (byte_ch.valid && !byte_ch.ready) begin
				// hold the offered byte
			end else if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				gap--;
			end else if (bytes_sent < byte_plan.size()) begin
				byte_ch.valid <= 1'b1;
				byte_ch.byte_in <= byte_plan[bytes_sent].byte_val;
				byte_ch.end_of_text <= byte_plan[bytes_sent].eot;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// Accept char transactions with random stalls and compare with the oldest prediction
	initial begin : drain_chars
		decoded_char_t want;
		int stall;
		char_ch.ready <= 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (char_ch.valid && char_ch.ready) begin
				if (pending_chars.size() == 0) begin
					$display("%0t: unexpected char: expected none, got cp=%h final=%b trunc=%b",
						$time, char_ch.code_point, char_ch.final_char, char_ch.truncated);
					errors++;
				end else begin
					want = pending_chars.pop_front();
					if (char_ch.code_point !== want.code_point) begin
						$display("%0t: code_point expected %h got %h",
							$time, want.code_point, char_ch.code_point);
						errors++;
					end
					if (char_ch.final_char !== want.final_char) begin
						$display("%0t: final_char expected %b got %b",
							$time, want.final_char, char_ch.final_char);
						errors++;
					end
					if (char_ch.truncated !== want.truncated) begin
						$display("%0t: truncated expected %b got %b",
							$time, want.truncated, char_ch.truncated);
						errors++;
					end
				end
			end
			if (stall > 0) begin
				char_ch.ready <= 1'b0;
				stall--;
			end else begin
				char_ch.ready <= 1'b1;
				if (!settle_phase && $urandom_range(0, 7) == 0)
					stall = $urandom_range(1, 11);
			end
		end
	end

	// Build the text, reset once, then wait for the last character to drain
	initial begin : run_test
		acc_bits = '0;
		conts_left = PEND_NONE;
		bytes_sent = 0;
		errors = 0;
		settle_phase = 1'b0;
		for (int i = 0; i < N_DIRECTED; i++)
			byte_plan.push_back(directed_rows[i]);
		add_random_text(TEXT_BYTES);
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (bytes_sent < byte_plan.size() || pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
